### design/ybf_pkg.sv
package ybf_pkg;

  // Framing bytes of a packet.
  localparam logic [7:0] START_SHORT = 8'h01;
  localparam logic [7:0] START_LONG  = 8'h02;
  localparam logic [7:0] FILLER      = 8'h1A;
  localparam logic [7:0] NUM_MASK    = 8'hFF;

  // CRC-16/XMODEM generator polynomial.
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // One classified slot as it travels from the front part to the back part.
  typedef struct packed {
    logic [7:0] payload;
    logic [7:0] number;
    logic       first;
    logic       last;
    logic       is_long;
  } slot_t;

  // Feeds one byte into the CRC, MSB first, no reflection.
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (crc[15]) begin
        crc = {crc[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc = {crc[14:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

### design/ymodem_block_framer_top.sv
// Channel | Handshake           | Item fields
// in      | in_valid / in_ready | content_byte, is_content, block_number, long_block
// out     | out_valid/out_ready | out_byte, packet_end
//
// Bytes leave through the single output register: a middle slot emits its payload only, a
// first slot adds start, number and complement before it, a last slot the CRC bytes after.
// A slot queue of QUEUE_DEPTH entries sits between the classifying front and the
// byte sequencer; the input takes up to QUEUE_DEPTH items while the output is stalled.
// in_ready is low whenever the queue is full, even in a cycle in which the back pops it.
// Reset (rst, synchronous) empties the queue and awaits the first slot of a packet.
module ymodem_block_framer_top #(
  parameter int SHORT_BLOCK = 128,
  parameter int LONG_BLOCK  = 1024,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] content_byte,
  input  logic       is_content,
  input  logic [7:0] block_number,
  input  logic       long_block,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       packet_end
);

  logic           push;
  ybf_pkg::slot_t push_slot;
  logic           q_full;
  logic           pop;
  logic           head_valid;
  ybf_pkg::slot_t head;

  ybf_front #(
    .SHORT_BLOCK(SHORT_BLOCK),
    .LONG_BLOCK (LONG_BLOCK)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .content_byte(content_byte),
    .is_content  (is_content),
    .block_number(block_number),
    .long_block  (long_block),
    .q_full      (q_full),
    .push        (push),
    .push_slot   (push_slot)
  );

  ybf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_slot (push_slot),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  ybf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_valid(head_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .packet_end(packet_end)
  );

endmodule

### design/ybf_front.sv
module ybf_front #(
  parameter int SHORT_BLOCK = 128,
  parameter int LONG_BLOCK  = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         content_byte,
  input  logic               is_content,
  input  logic [7:0]         block_number,
  input  logic               long_block,
  input  logic               q_full,
  output logic               push,
  output ybf_pkg::slot_t     push_slot
);

  localparam int MAX_LEN = (SHORT_BLOCK > LONG_BLOCK) ? SHORT_BLOCK : LONG_BLOCK;
  localparam int CNT_W   = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
  localparam logic [CNT_W:0] SHORT_SLOTS = (CNT_W + 1)'(SHORT_BLOCK);
  localparam logic [CNT_W:0] LONG_SLOTS  = (CNT_W + 1)'(LONG_BLOCK);

  logic [CNT_W-1:0] slot_count;
  logic             block_is_long;

  logic             first;
  logic             is_long;
  logic [CNT_W:0]   count_inc;
  logic [CNT_W:0]   length;
  logic             last;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  // Classify the slot: packet size is sampled on the first slot only.
  assign first     = (slot_count == '0);
  assign is_long   = first ? long_block : block_is_long;
  assign length    = is_long ? LONG_SLOTS : SHORT_SLOTS;
  assign count_inc = {1'b0, slot_count} + (CNT_W + 1)'(1);
  assign last      = (count_inc >= length);

  always_comb begin
    push_slot.payload = is_content ? content_byte : ybf_pkg::FILLER;
    push_slot.number  = block_number;
    push_slot.first   = first;
    push_slot.last    = last;
    push_slot.is_long = is_long;
  end

  // Slot counter and sampled packet size.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count    <= '0;
      block_is_long <= 1'b0;
    end else if (push) begin
      block_is_long <= is_long;
      slot_count    <= last ? '0 : count_inc[CNT_W-1:0];
    end
  end

`ifndef SYNTH
  // The count never reaches the length of the packet in progress.
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, slot_count} < (block_is_long ? LONG_SLOTS : SHORT_SLOTS))
    else $error("slot count out of range");
`endif

endmodule

### design/ybf_queue.sv
module ybf_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ybf_pkg::slot_t push_slot,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output ybf_pkg::slot_t head
);

  localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  ybf_pkg::slot_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_slot;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue read while empty");
`endif

endmodule

### design/ybf_back.sv
module ybf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  ybf_pkg::slot_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_byte,
  output logic           packet_end
);

  typedef enum logic [2:0] {
    PH_START,
    PH_NUM,
    PH_CPL,
    PH_DATA,
    PH_CRC_HI,
    PH_CRC_LO
  } phase_t;

  phase_t      phase;
  phase_t      cur;
  phase_t      phase_next;
  logic        load;
  logic        emit;
  logic [7:0]  byte_next;
  logic        end_next;
  logic [15:0] crc;
  logic [15:0] crc_fed;

  // The output register takes a new byte when it is empty or being drained.
  assign load = !out_valid || out_ready;
  assign emit = load && head_valid;

  // A slot that does not open a packet goes straight to its payload byte.
  assign cur = (phase == PH_START && !head.first) ? PH_DATA : phase;

  assign crc_fed = ybf_pkg::crc16_feed(head.first ? 16'h0000 : crc, head.payload);

  // Pick the byte for the current phase of the head slot.
  always_comb begin
    byte_next  = head.payload;
    end_next   = 1'b0;
    phase_next = cur;
    pop        = 1'b0;
    unique case (cur)
      PH_START: begin
        byte_next  = head.is_long ? ybf_pkg::START_LONG : ybf_pkg::START_SHORT;
        phase_next = PH_NUM;
      end
      PH_NUM: begin
        byte_next  = head.number;
        phase_next = PH_CPL;
      end
      PH_CPL: begin
        byte_next  = ybf_pkg::NUM_MASK - head.number;
        phase_next = PH_DATA;
      end
      PH_DATA: begin
        byte_next = head.payload;
        if (head.last) begin
          phase_next = PH_CRC_HI;
        end else begin
          phase_next = PH_START;
          pop        = emit;
        end
      end
      PH_CRC_HI: begin
        byte_next  = crc[15:8];
        phase_next = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        byte_next  = crc[7:0];
        end_next   = 1'b1;
        phase_next = PH_START;
        pop        = emit;
      end
      default: begin
        phase_next = PH_START;
      end
    endcase
  end

  // Phase, output register and running CRC.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      out_valid  <= 1'b0;
      out_byte   <= '0;
      packet_end <= 1'b0;
      crc        <= '0;
    end else begin
      if (load) begin
        out_valid <= head_valid;
      end
      if (emit) begin
        phase      <= phase_next;
        out_byte   <= byte_next;
        packet_end <= end_next;
        if (cur == PH_DATA) begin
          crc <= crc_fed;
        end
      end
    end
  end

`ifndef SYNTH
  // Once the last CRC byte is loaded into the output register, the phase returns to PH_START.
  a_restart_after_end: assert property (@(posedge clk) disable iff (rst)
    (emit && cur == PH_CRC_LO) |=> (phase == PH_START))
    else $error("packet did not restart after CRC");
`endif

endmodule
